[hdl/twhb_pkg.sv]
// Shared constants, operation codes and index helpers for the timed window history buffer.
// No dependencies; the top level and twhb_alu refer to it by scoped names.
`timescale 1ns / 1ps
package twhb_pkg;

    localparam int DEPTH        = 64;
    localparam int STAMP_BITS   = 48;
    localparam int PAYLOAD_BITS = 64;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);

    localparam logic [STAMP_BITS-1:0] WINDOW_RESET = STAMP_BITS'(1000000);

    // operation codes
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_CLEAR   = 3'd1;
    localparam logic [2:0] OP_LOOKUP  = 3'd2;
    localparam logic [2:0] OP_SEGMENT = 3'd3;
    localparam logic [2:0] OP_PRUNE   = 3'd4;

    // physical slot of the entry idx places after the head
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] idx);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + (PTR_W+1)'(idx);
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // ring pointer increment
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

endpackage

[hdl/timed_window_history_buffer.sv]
// Top level of the timed window history buffer: sequencer, ring state and result register.
// Depends on twhb_pkg, twhb_ram and twhb_alu.
//
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+---------------------------
//  request  | operation, stamp, end_stamp, payload           | start & !busy
//  config   | cfg_data                                       | cfg_we (idle only)
//  result   | hit, out_stamp, out_payload, last, period,     | done, one cycle, no stall
//           | span, count, dropped                           |
//
// Push and prune: accept, compute the cutoff, then a read and check step per pruned entry,
// with no check when fewer than two entries are held. Clear, ignored push and unknown codes
// go straight to the final result state. Lookup and segment walk the ring entry by entry
// through the shared RAM read address; segment results leave as entries are found.
// A config write starts a prune that gives no result and holds busy meanwhile.
// Reset empties the ring and loads the default window; the stores need no clearing.
`timescale 1ns / 1ps
module timed_window_history_buffer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        operation,
    input  logic [twhb_pkg::STAMP_BITS-1:0]   stamp,
    input  logic [twhb_pkg::STAMP_BITS-1:0]   end_stamp,
    input  logic [twhb_pkg::PAYLOAD_BITS-1:0] payload,
    input  logic                              cfg_we,
    input  logic [twhb_pkg::STAMP_BITS-1:0]   cfg_data,
    output logic                              done,
    output logic                              hit,
    output logic [twhb_pkg::STAMP_BITS-1:0]   out_stamp,
    output logic [twhb_pkg::PAYLOAD_BITS-1:0] out_payload,
    output logic                              last,
    output logic [twhb_pkg::STAMP_BITS-1:0]   period,
    output logic [twhb_pkg::STAMP_BITS-1:0]   span,
    output logic [twhb_pkg::CNT_W-1:0]        count,
    output logic                              dropped
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_PR_START = 7'b0000010,
        S_PR_RD    = 7'b0000100,
        S_PR_CHK   = 7'b0001000,
        S_SC_RD    = 7'b0010000,
        S_SC_CHK   = 7'b0100000,
        S_FIN      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [twhb_pkg::STAMP_BITS-1:0]   window_reg, window_next;
    logic [twhb_pkg::PTR_W-1:0]        head_reg, head_next;
    logic [twhb_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   period_reg, period_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   newest_reg, newest_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   oldest_reg, oldest_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   cutoff_reg, cutoff_next;
    logic                              prune_en_reg, prune_en_next;
    logic                              emit_reg, emit_next;
    logic                              seg_reg, seg_next;
    logic [twhb_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   key_reg, key_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   end_reg, end_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   pend_stamp_reg, pend_stamp_next;
    logic [twhb_pkg::PAYLOAD_BITS-1:0] pend_pay_reg, pend_pay_next;
    logic                              drop_reg, drop_next;

    logic                              done_reg, done_next;
    logic                              hit_reg, hit_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   ostamp_reg, ostamp_next;
    logic [twhb_pkg::PAYLOAD_BITS-1:0] opay_reg, opay_next;
    logic                              last_reg, last_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   operiod_reg, operiod_next;
    logic [twhb_pkg::STAMP_BITS-1:0]   span_reg, span_next;
    logic [twhb_pkg::CNT_W-1:0]        ocount_reg, ocount_next;
    logic                              odrop_reg, odrop_next;

    logic                              ram_we;
    logic [twhb_pkg::PTR_W-1:0]        ram_waddr;
    logic [twhb_pkg::PTR_W-1:0]        ram_raddr;
    logic [twhb_pkg::STAMP_BITS-1:0]   rd_stamp;
    logic [twhb_pkg::PAYLOAD_BITS-1:0] rd_pay;

    logic [twhb_pkg::STAMP_BITS-1:0]   alu_a, alu_b, alu_diff;
    logic                              alu_borrow;
    logic                              emit_now, emit_last;
    logic [twhb_pkg::STAMP_BITS-1:0]   span_calc;

    // entry stores
    twhb_ram #(.WIDTH(twhb_pkg::STAMP_BITS), .DEPTH(twhb_pkg::DEPTH)) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (stamp),
        .raddr (ram_raddr),
        .rdata (rd_stamp)
    );

    twhb_ram #(.WIDTH(twhb_pkg::PAYLOAD_BITS), .DEPTH(twhb_pkg::DEPTH)) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (payload),
        .raddr (ram_raddr),
        .rdata (rd_pay)
    );

    // shared subtract / compare unit
    twhb_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    // operand select for the shared unit
    always_comb
    begin
        alu_a = stamp;
        alu_b = newest_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (operation == twhb_pkg::OP_SEGMENT)
                begin
                    alu_a = end_stamp;
                    alu_b = stamp;
                end
            end
            S_PR_START:
            begin
                alu_a = newest_reg;
                alu_b = window_reg;
            end
            S_PR_CHK:
            begin
                alu_a = rd_stamp;
                alu_b = cutoff_reg;
            end
            S_SC_CHK:
            begin
                alu_a = seg_reg ? rd_stamp : key_reg;
                alu_b = seg_reg ? key_reg : rd_stamp;
            end
            default:
            begin
                alu_a = stamp;
                alu_b = newest_reg;
            end
        endcase
    end

    // sequencer and ring bookkeeping
    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        period_next     = period_reg;
        newest_next     = newest_reg;
        oldest_next     = oldest_reg;
        cutoff_next     = cutoff_reg;
        prune_en_next   = prune_en_reg;
        emit_next       = emit_reg;
        seg_next        = seg_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        end_next        = end_reg;
        pend_valid_next = pend_valid_reg;
        pend_stamp_next = pend_stamp_reg;
        pend_pay_next   = pend_pay_reg;
        drop_next       = drop_reg;
        ram_we          = 1'b0;
        ram_waddr       = twhb_pkg::slot_of(head_reg, count_reg);
        ram_raddr       = head_reg;
        emit_now        = 1'b0;
        emit_last       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                pend_valid_next = 1'b0;
                drop_next       = 1'b0;
                if (cfg_we)
                begin
                    if (cfg_data != '0)
                    begin
                        window_next = cfg_data;
                    end
                    emit_next  = 1'b0;
                    state_next = S_PR_START;
                end
                else if (start)
                begin
                    emit_next = 1'b1;
                    key_next  = stamp;
                    end_next  = end_stamp;
                    idx_next  = '0;
                    case (operation)
                        twhb_pkg::OP_PUSH:
                        begin
                            if (stamp == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                newest_next = stamp;
                                state_next  = S_PR_START;
                                ram_we      = 1'b1;
                                if (count_reg == '0 || alu_borrow)
                                begin
                                    // empty ring starts at head; older stamp at slot zero
                                    if (count_reg != '0)
                                    begin
                                        period_next = '0;
                                        head_next   = '0;
                                        ram_waddr   = '0;
                                    end
                                    count_next  = twhb_pkg::CNT_W'(1);
                                    oldest_next = stamp;
                                end
                                else
                                begin
                                    period_next = alu_diff;
                                    if (count_reg == twhb_pkg::CNT_W'(twhb_pkg::DEPTH))
                                    begin
                                        // full: overwrite the oldest slot
                                        ram_waddr = head_reg;
                                        head_next = twhb_pkg::ptr_inc(head_reg);
                                        drop_next = 1'b1;
                                    end
                                    else
                                    begin
                                        count_next = count_reg + twhb_pkg::CNT_W'(1);
                                    end
                                end
                            end
                        end
                        twhb_pkg::OP_CLEAR:
                        begin
                            count_next  = '0;
                            head_next   = '0;
                            period_next = '0;
                            state_next  = S_FIN;
                        end
                        twhb_pkg::OP_LOOKUP:
                        begin
                            seg_next   = 1'b0;
                            state_next = (stamp == '0) ? S_FIN : S_SC_RD;
                        end
                        twhb_pkg::OP_SEGMENT:
                        begin
                            seg_next   = 1'b1;
                            state_next = alu_borrow ? S_FIN : S_SC_RD;
                        end
                        twhb_pkg::OP_PRUNE:
                        begin
                            state_next = S_PR_START;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_PR_START:
            begin
                // cutoff = newest - window, pruning only when newest > window
                cutoff_next   = alu_diff;
                prune_en_next = !alu_borrow && (alu_diff != '0);
                state_next    = S_PR_RD;
            end
            S_PR_RD:
            begin
                ram_raddr = head_reg;
                if (count_reg > twhb_pkg::CNT_W'(1))
                begin
                    state_next = S_PR_CHK;
                end
                else
                begin
                    state_next = emit_reg ? S_FIN : S_IDLE;
                end
            end
            S_PR_CHK:
            begin
                oldest_next = rd_stamp;
                if (prune_en_reg && alu_borrow)
                begin
                    head_next  = twhb_pkg::ptr_inc(head_reg);
                    count_next = count_reg - twhb_pkg::CNT_W'(1);
                    state_next = S_PR_RD;
                end
                else
                begin
                    state_next = emit_reg ? S_FIN : S_IDLE;
                end
            end
            S_SC_RD:
            begin
                ram_raddr = twhb_pkg::slot_of(head_reg, idx_reg);
                state_next = (idx_reg < count_reg) ? S_SC_CHK : S_FIN;
            end
            S_SC_CHK:
            begin
                idx_next   = idx_reg + twhb_pkg::CNT_W'(1);
                state_next = S_SC_RD;
                if (!seg_reg)
                begin
                    // lookup: stop at the first entry after the key
                    if (alu_borrow)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_stamp_next = rd_stamp;
                        pend_pay_next   = rd_pay;
                    end
                end
                else if (!alu_borrow)
                begin
                    if (end_reg < rd_stamp)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        // segment match: release the previous one, hold this one
                        emit_now        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_stamp_next = rd_stamp;
                        pend_pay_next   = rd_pay;
                    end
                end
            end
            S_FIN:
            begin
                emit_now   = 1'b1;
                emit_last  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register load
    always_comb
    begin
        span_calc    = (count_reg >= twhb_pkg::CNT_W'(2)) ? newest_reg - oldest_reg : '0;
        done_next    = emit_now;
        hit_next     = hit_reg;
        ostamp_next  = ostamp_reg;
        opay_next    = opay_reg;
        last_next    = last_reg;
        operiod_next = operiod_reg;
        span_next    = span_reg;
        ocount_next  = ocount_reg;
        odrop_next   = odrop_reg;
        if (emit_now)
        begin
            hit_next     = pend_valid_reg;
            ostamp_next  = pend_valid_reg ? pend_stamp_reg : '0;
            opay_next    = pend_valid_reg ? pend_pay_reg : '0;
            last_next    = emit_last;
            operiod_next = period_reg;
            span_next    = span_calc;
            ocount_next  = count_reg;
            odrop_next   = drop_reg && emit_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_reg     <= twhb_pkg::WINDOW_RESET;
            head_reg       <= '0;
            count_reg      <= '0;
            period_reg     <= '0;
            prune_en_reg   <= 1'b0;
            emit_reg       <= 1'b0;
            seg_reg        <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            drop_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            period_reg     <= period_next;
            prune_en_reg   <= prune_en_next;
            emit_reg       <= emit_next;
            seg_reg        <= seg_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            drop_reg       <= drop_next;
            done_reg       <= done_next;
        end
    end

    // payload and result registers
    always_ff @(posedge clk)
    begin
        newest_reg     <= newest_next;
        oldest_reg     <= oldest_next;
        cutoff_reg     <= cutoff_next;
        key_reg        <= key_next;
        end_reg        <= end_next;
        pend_stamp_reg <= pend_stamp_next;
        pend_pay_reg   <= pend_pay_next;
        hit_reg        <= hit_next;
        ostamp_reg     <= ostamp_next;
        opay_reg       <= opay_next;
        last_reg       <= last_next;
        operiod_reg    <= operiod_next;
        span_reg       <= span_next;
        ocount_reg     <= ocount_next;
        odrop_reg      <= odrop_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign out_stamp   = ostamp_reg;
    assign out_payload = opay_reg;
    assign last        = last_reg;
    assign period      = operiod_reg;
    assign span        = span_reg;
    assign count       = ocount_reg;
    assign dropped     = odrop_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= twhb_pkg::CNT_W'(twhb_pkg::DEPTH))
        else $error("entry count above ring depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy)
        else $error("non-final result outside a segment walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> last)
        else $error("miss result not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && dropped |-> !hit && last)
        else $error("drop flag on a non-push result");

endmodule

[hdl/twhb_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module twhb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/twhb_alu.sv]
// Shared stamp subtractor: difference and borrow (a below b) for the stamp compares but the segment end check.
// Depends on twhb_pkg.
`timescale 1ns / 1ps
module twhb_alu (
    input  logic [twhb_pkg::STAMP_BITS-1:0] a,
    input  logic [twhb_pkg::STAMP_BITS-1:0] b,
    output logic [twhb_pkg::STAMP_BITS-1:0] diff,
    output logic                            borrow
);

    // one wide subtract, borrow out marks a < b
    always_comb
    begin
        {borrow, diff} = {1'b0, a} - {1'b0, b};
    end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the timed window history buffer.
// Depends on twhb_pkg and timed_window_history_buffer; a built-in predictor checks every result.
`timescale 1ns / 1ps
module tb_top;

    localparam int LIMIT_CYCLES = 600000;
    localparam int IDLE_CYCLES  = 2 * twhb_pkg::DEPTH + 20;
    localparam int EXP_DEPTH    = 128;
    localparam logic [twhb_pkg::STAMP_BITS-1:0] STAMP_MAX = '1;
    // codes the block does not define
    localparam logic [2:0]  OP_SPARE_5   = 3'd5;
    localparam logic [2:0]  OP_SPARE_6   = 3'd6;
    localparam logic [2:0]  OP_SPARE_7   = 3'd7;

    typedef struct packed {
        logic                              hit;
        logic [twhb_pkg::STAMP_BITS-1:0]   stamp;
        logic [twhb_pkg::PAYLOAD_BITS-1:0] payload;
        logic                              last;
        logic [twhb_pkg::STAMP_BITS-1:0]   period;
        logic [twhb_pkg::STAMP_BITS-1:0]   span;
        logic [twhb_pkg::CNT_W-1:0]        count;
        logic                              dropped;
    } status_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [2:0]                        operation;
    logic [twhb_pkg::STAMP_BITS-1:0]   stamp;
    logic [twhb_pkg::STAMP_BITS-1:0]   end_stamp;
    logic [twhb_pkg::PAYLOAD_BITS-1:0] payload;
    logic                              cfg_we;
    logic [twhb_pkg::STAMP_BITS-1:0]   cfg_data;
    logic                              done;
    logic                              hit;
    logic [twhb_pkg::STAMP_BITS-1:0]   out_stamp;
    logic [twhb_pkg::PAYLOAD_BITS-1:0] out_payload;
    logic                              last;
    logic [twhb_pkg::STAMP_BITS-1:0]   period;
    logic [twhb_pkg::STAMP_BITS-1:0]   span;
    logic [twhb_pkg::CNT_W-1:0]        count;
    logic                              dropped;

    // shadow of the ring
    logic [twhb_pkg::STAMP_BITS-1:0]   hist_stamp [twhb_pkg::DEPTH];
    logic [twhb_pkg::PAYLOAD_BITS-1:0] hist_data  [twhb_pkg::DEPTH];
    int                                hist_head;
    int                                hist_count;
    logic [twhb_pkg::STAMP_BITS-1:0]   hist_period;
    logic [twhb_pkg::STAMP_BITS-1:0]   window_len;

    // expected results, oldest at exp_rd_ptr
    status_t                           exp_fifo [EXP_DEPTH];
    int                                exp_wr_ptr;
    int                                exp_rd_ptr;
    int                                error_count;
    int                                cycle_count;
    bit                                quiet_phase;

    timed_window_history_buffer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .stamp      (stamp),
        .end_stamp  (end_stamp),
        .payload    (payload),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .done       (done),
        .hit        (hit),
        .out_stamp  (out_stamp),
        .out_payload(out_payload),
        .last       (last),
        .period     (period),
        .span       (span),
        .count      (count),
        .dropped    (dropped)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int ring_slot(int i);
        return (hist_head + i) % twhb_pkg::DEPTH;
    endfunction

    function automatic logic [twhb_pkg::STAMP_BITS-1:0] newest_entry();
        return hist_stamp[ring_slot(hist_count - 1)];
    endfunction

    function automatic logic [twhb_pkg::STAMP_BITS-1:0] ring_span();
        if (hist_count < 2)
        begin
            return '0;
        end
        return newest_entry() - hist_stamp[hist_head];
    endfunction

    function automatic void trim_to_window();
        logic [twhb_pkg::STAMP_BITS-1:0] cutoff;
        if (hist_count == 0 || newest_entry() <= window_len)
        begin
            return;
        end
        cutoff = newest_entry() - window_len;
        while (hist_count > 1 && hist_stamp[hist_head] < cutoff)
        begin
            hist_head  = (hist_head + 1) % twhb_pkg::DEPTH;
            hist_count = hist_count - 1;
        end
    endfunction

    function automatic void add_status(logic h, logic [twhb_pkg::STAMP_BITS-1:0] st,
                                       logic [twhb_pkg::PAYLOAD_BITS-1:0] pl, logic lst,
                                       logic drp);
        status_t s;
        s.hit     = h;
        s.stamp   = h ? st : '0;
        s.payload = h ? pl : '0;
        s.last    = lst;
        s.period  = hist_period;
        s.span    = ring_span();
        s.count   = twhb_pkg::CNT_W'(hist_count);
        s.dropped = drp;
        exp_fifo[exp_wr_ptr % EXP_DEPTH] = s;
        exp_wr_ptr = exp_wr_ptr + 1;
    endfunction

    function automatic void predict_request(logic [2:0] op,
                                            logic [twhb_pkg::STAMP_BITS-1:0] st,
                                            logic [twhb_pkg::STAMP_BITS-1:0] en,
                                            logic [twhb_pkg::PAYLOAD_BITS-1:0] pl);
        logic drp;
        int   best;
        int   found;
        int   s;
        drp   = 1'b0;
        found = 0;
        best  = 0;
        case (op)
            twhb_pkg::OP_PUSH:
            begin
                if (st != '0)
                begin
                    if (hist_count > 0)
                    begin
                        if (st < newest_entry())
                        begin
                            hist_count  = 0;
                            hist_head   = 0;
                            hist_period = '0;
                        end
                        else
                        begin
                            hist_period = st - newest_entry();
                        end
                    end
                    if (hist_count >= twhb_pkg::DEPTH)
                    begin
                        hist_head  = (hist_head + 1) % twhb_pkg::DEPTH;
                        hist_count = hist_count - 1;
                        drp        = 1'b1;
                    end
                    hist_stamp[ring_slot(hist_count)] = st;
                    hist_data[ring_slot(hist_count)]  = pl;
                    hist_count = hist_count + 1;
                    trim_to_window();
                end
                add_status(1'b0, '0, '0, 1'b1, drp);
            end
            twhb_pkg::OP_CLEAR:
            begin
                hist_count  = 0;
                hist_head   = 0;
                hist_period = '0;
                add_status(1'b0, '0, '0, 1'b1, 1'b0);
            end
            twhb_pkg::OP_LOOKUP:
            begin
                if (st != '0)
                begin
                    for (int i = 0; i < hist_count; i++)
                    begin
                        if (hist_stamp[ring_slot(i)] > st)
                        begin
                            break;
                        end
                        best  = ring_slot(i);
                        found = 1;
                    end
                end
                add_status(found != 0, hist_stamp[best], hist_data[best], 1'b1, 1'b0);
            end
            twhb_pkg::OP_SEGMENT:
            begin
                if (en >= st)
                begin
                    for (int i = 0; i < hist_count; i++)
                    begin
                        s = ring_slot(i);
                        if (hist_stamp[s] < st)
                        begin
                            continue;
                        end
                        if (hist_stamp[s] > en)
                        begin
                            break;
                        end
                        add_status(1'b1, hist_stamp[s], hist_data[s], 1'b0, 1'b0);
                        found++;
                    end
                end
                if (found == 0)
                begin
                    add_status(1'b0, '0, '0, 1'b1, 1'b0);
                end
                else
                begin
                    exp_fifo[(exp_wr_ptr - 1) % EXP_DEPTH].last = 1'b1;
                end
            end
            twhb_pkg::OP_PRUNE:
            begin
                trim_to_window();
                add_status(1'b0, '0, '0, 1'b1, 1'b0);
            end
            default:
            begin
                add_status(1'b0, '0, '0, 1'b1, 1'b0);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
    endtask

    // compare every result with the oldest prediction
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && done)
        begin
            if (exp_wr_ptr == exp_rd_ptr)
            begin
                report_mismatch("unexpected result", 64'(out_stamp), 64'd0);
            end
            else
            begin
                want = exp_fifo[exp_rd_ptr % EXP_DEPTH];
                exp_rd_ptr = exp_rd_ptr + 1;
                if (hit !== want.hit)
                    report_mismatch("hit", 64'(hit), 64'(want.hit));
                if (out_stamp !== want.stamp)
                    report_mismatch("out_stamp", 64'(out_stamp), 64'(want.stamp));
                if (out_payload !== want.payload)
                    report_mismatch("out_payload", out_payload, want.payload);
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
                if (period !== want.period)
                    report_mismatch("period", 64'(period), 64'(want.period));
                if (span !== want.span)
                    report_mismatch("span", 64'(span), 64'(want.span));
                if (count !== want.count)
                    report_mismatch("count", 64'(count), 64'(want.count));
                if (dropped !== want.dropped)
                    report_mismatch("dropped", 64'(dropped), 64'(want.dropped));
            end
        end
    end

    // ---------------------------------------------------------------- driving

    // present one request and hold it until accepted
    task automatic send_request(logic [2:0] op, logic [twhb_pkg::STAMP_BITS-1:0] st,
                                logic [twhb_pkg::STAMP_BITS-1:0] en,
                                logic [twhb_pkg::PAYLOAD_BITS-1:0] pl);
        start     <= 1'b1;
        operation <= op;
        stamp     <= st;
        end_stamp <= en;
        payload   <= pl;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_request(op, st, en, pl);
    endtask

    // random idle between requests, mostly short
    task automatic sender_gap();
        int n;
        int r;
        r = $urandom_range(99);
        if (quiet_phase || r < 60)
            n = 0;
        else if (r < 94)
            n = $urandom_range(3, 1);
        else
            n = $urandom_range(40, 8);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (exp_wr_ptr != exp_rd_ptr)
        begin
            @(posedge clk);
        end
    endtask

    // window register write, only while idle
    task automatic write_window(logic [twhb_pkg::STAMP_BITS-1:0] value);
        drain_results();
        repeat (IDLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (value != '0)
            window_len = value;
        trim_to_window();
    endtask

    function automatic logic [twhb_pkg::PAYLOAD_BITS-1:0] rand_payload();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [twhb_pkg::STAMP_BITS-1:0] rand_stamp();
        return {16'($urandom()), $urandom()};
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_request(twhb_pkg::OP_LOOKUP, 48'd5, '0, '0);
        send_request(twhb_pkg::OP_SEGMENT, 48'd0, STAMP_MAX, '0);
        send_request(twhb_pkg::OP_PUSH, 48'd0, '0, '1);
        send_request(twhb_pkg::OP_PUSH, 48'd1, '0, '0);
        send_request(twhb_pkg::OP_PUSH, 48'd10, '0, '1);
        send_request(twhb_pkg::OP_PUSH, 48'd10, '0, 64'h5555_AAAA_5555_AAAA);
        send_request(twhb_pkg::OP_LOOKUP, 48'd0, '0, '0);
        send_request(twhb_pkg::OP_LOOKUP, 48'd9, '0, '0);
        send_request(twhb_pkg::OP_LOOKUP, STAMP_MAX, '0, '0);
        send_request(twhb_pkg::OP_SEGMENT, 48'd20, 48'd5, '0);
        send_request(twhb_pkg::OP_SEGMENT, 48'd2, 48'd9, '0);
        send_request(twhb_pkg::OP_SEGMENT, 48'd0, STAMP_MAX, '0);
        send_request(twhb_pkg::OP_PUSH, STAMP_MAX, STAMP_MAX, 64'hAAAA_5555_AAAA_5555);
        send_request(twhb_pkg::OP_PUSH, 48'd3, '0, 64'h1);
        send_request(twhb_pkg::OP_LOOKUP, 48'd2, '0, '0);
        send_request(twhb_pkg::OP_PRUNE, '0, '0, '0);
        send_request(OP_SPARE_5, STAMP_MAX, STAMP_MAX, '1);
        send_request(OP_SPARE_6, '0, '0, '0);
        send_request(OP_SPARE_7, 48'd7, 48'd7, '0);
        send_request(twhb_pkg::OP_CLEAR, '0, '0, '0);
        send_request(twhb_pkg::OP_LOOKUP, 48'd3, '0, '0);
    endtask

    // overfill the ring so the oldest entries fall out
    task automatic test_full_ring();
        write_window(STAMP_MAX);
        quiet_phase = 1'b1;
        for (int i = 1; i <= twhb_pkg::DEPTH + 6; i++)
        begin
            send_request(twhb_pkg::OP_PUSH, 48'(i * 3), '0, rand_payload());
        end
        quiet_phase = 1'b0;
        send_request(twhb_pkg::OP_SEGMENT, '0, STAMP_MAX, '0);
        send_request(twhb_pkg::OP_LOOKUP, 48'd100, '0, '0);
    endtask

    // window sizes: smallest, ignored zero, default, and pruning on write
    task automatic test_window_settings();
        write_window(48'd1);
        send_request(twhb_pkg::OP_SEGMENT, '0, STAMP_MAX, '0);
        send_request(twhb_pkg::OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < 8; i++)
        begin
            send_request(twhb_pkg::OP_PUSH, 48'(100 + i / 2 * 1), '0, rand_payload());
            sender_gap();
        end
        write_window(48'd0);
        send_request(twhb_pkg::OP_PRUNE, '0, '0, '0);
        write_window(48'd50);
        for (int i = 1; i <= 10; i++)
        begin
            send_request(twhb_pkg::OP_PUSH, 48'(200 + i * 20), '0, rand_payload());
        end
        write_window(48'd30);
        send_request(twhb_pkg::OP_SEGMENT, '0, STAMP_MAX, '0);
        write_window(twhb_pkg::WINDOW_RESET);
    endtask

    // mostly ordered pushes with queries in range, some noise
    task automatic test_random(int n_items);
        logic [twhb_pkg::STAMP_BITS-1:0] now;
        logic [twhb_pkg::STAMP_BITS-1:0] lo;
        int                              r;
        now = 48'd1000;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 60 == 0)
                quiet_phase = ($urandom_range(2) == 0);
            if (k == n_items / 2)
                drain_results();
            if (k % 90 == 45)
                write_window(48'($urandom_range(200000, 1)));
            r  = $urandom_range(99);
            lo = (now > 48'd3000) ? now - 48'($urandom_range(3000)) : '0;
            if (r < 50)
            begin
                now = now + 48'($urandom_range(r < 5 ? 400000 : 9000));
                send_request(twhb_pkg::OP_PUSH, now, rand_stamp(), rand_payload());
            end
            else if (r < 62)
                send_request(twhb_pkg::OP_LOOKUP, lo + 48'($urandom_range(4000)),
                             rand_stamp(), rand_payload());
            else if (r < 74)
                send_request(twhb_pkg::OP_SEGMENT, lo, lo + 48'($urandom_range(5000)),
                             rand_payload());
            else if (r < 80)
                send_request(twhb_pkg::OP_PRUNE, rand_stamp(), rand_stamp(),
                             rand_payload());
            else if (r < 83)
                send_request(twhb_pkg::OP_CLEAR, rand_stamp(), rand_stamp(),
                             rand_payload());
            else if (r < 88)
            begin
                // stamp jumps to a random value; the ring restarts when it is older
                now = rand_stamp();
                send_request(twhb_pkg::OP_PUSH, now, rand_stamp(), rand_payload());
            end
            else
                send_request(3'($urandom_range(7)), rand_stamp(), rand_stamp(),
                             rand_payload());
            if (now == '0)
                now = 48'd1;
            sender_gap();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = twhb_pkg::OP_PUSH;
        stamp       = '0;
        end_stamp   = '0;
        payload     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        exp_wr_ptr  = 0;
        exp_rd_ptr  = 0;
        hist_head   = 0;
        hist_count  = 0;
        hist_period = '0;
        window_len  = twhb_pkg::WINDOW_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_ring();
        test_window_settings();
        test_random(245);

        drain_results();
        repeat (IDLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
